// ===== rtl/las_pkg.sv =====
// Shared constants, types and state encoding for the life automaton step core.
// No dependencies.
package las_pkg;

    localparam int GRID_ROWS = 64;
    localparam int GRID_COLS = 64;
    localparam int ROW_W     = $clog2(GRID_ROWS);
    localparam int COL_W     = $clog2(GRID_COLS);
    localparam int CNT_W     = 7;
    localparam int GEN_W     = 32;
    localparam int NB_W      = 4;
    localparam int FUNC_W    = 3;
    localparam int CFG_IDX_W = 2;

    typedef logic [GRID_COLS-1:0] row_word_t;

    localparam logic [FUNC_W-1:0] FUNC_WRITE  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_TOGGLE = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_STEP   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_RULE_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS      = 2'd2;

    localparam logic [NB_W-1:0] NB_SURVIVE = 4'd2;
    localparam logic [NB_W-1:0] NB_BIRTH   = 4'd3;
    localparam logic [NB_W-1:0] NB_HIGHLIFE = 4'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC_RD,
        ST_ACC_MOD,
        ST_STEP_RD,
        ST_STEP_LOAD,
        ST_STEP_ROW,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/las_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module las_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/las_row_unit.sv =====
// Next-generation rule for one full row word from the rows above, here and below.
// Depends on las_pkg.
module las_row_unit (
    input  logic              rule_mode,
    input  las_pkg::row_word_t col_mask,
    input  las_pkg::row_word_t above,
    input  las_pkg::row_word_t here,
    input  las_pkg::row_word_t below,
    output las_pkg::row_word_t fresh
);
    import las_pkg::*;

    logic [GRID_COLS+1:0] a_p;
    logic [GRID_COLS+1:0] h_p;
    logic [GRID_COLS+1:0] b_p;
    logic [NB_W-1:0]      nb [GRID_COLS];

    assign a_p = {1'b0, above, 1'b0};
    assign h_p = {1'b0, here, 1'b0};
    assign b_p = {1'b0, below, 1'b0};

    always_comb
    begin
        for (int c = 0; c < GRID_COLS; c++)
        begin
            nb[c] = NB_W'(a_p[c]) + NB_W'(a_p[c+1]) + NB_W'(a_p[c+2])
                  + NB_W'(h_p[c]) + NB_W'(h_p[c+2])
                  + NB_W'(b_p[c]) + NB_W'(b_p[c+1]) + NB_W'(b_p[c+2]);
            if (nb[c] == NB_BIRTH)
            begin
                fresh[c] = col_mask[c];
            end
            else if (nb[c] == NB_SURVIVE)
            begin
                fresh[c] = col_mask[c] & here[c];
            end
            else if (nb[c] == NB_HIGHLIFE && rule_mode && !here[c])
            begin
                fresh[c] = col_mask[c];
            end
            else
            begin
                fresh[c] = 1'b0;
            end
        end
    end

endmodule

// ===== rtl/life_automaton_step_core.sv =====
// Life automaton step core: cell grid in RAM, one row rule unit reused per row.
// Write/toggle/read: ACC_RD, ACC_MOD, DONE; out of range skips ACC_MOD. Step:
// STEP_RD, STEP_LOAD, a STEP_ROW per used row, DONE; with no rows, STEP_RD to DONE.
// Clear and other codes go to DONE. One request at a time: in_ready only in IDLE.
// Reset: async active low; per-row valid flags make the grid read dead at once.
// Depends on las_pkg, las_ram, las_row_unit.
module life_automaton_step_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [las_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [las_pkg::CNT_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [las_pkg::FUNC_W-1:0]    func,
    input  logic [las_pkg::ROW_W-1:0]     cell_row,
    input  logic [las_pkg::COL_W-1:0]     cell_col,
    input  logic                          cell_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          cell_state,
    output logic                          evolved,
    output logic [las_pkg::GEN_W-1:0]     generation_count,
    output logic                          out_of_range
);
    import las_pkg::*;

    state_t             state_reg;
    state_t             state_next;
    logic               rule_mode_reg;
    logic [CNT_W-1:0]   rows_cfg_reg;
    logic [CNT_W-1:0]   cols_cfg_reg;
    logic [GEN_W-1:0]   gen_reg;
    logic [GRID_ROWS-1:0] row_valid_reg;
    logic               rd_valid_reg;
    logic               out_valid_reg;

    logic [FUNC_W-1:0]  func_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [COL_W-1:0]   col_reg;
    logic               value_reg;
    logic [ROW_W-1:0]   r_reg;
    row_word_t          above_reg;
    row_word_t          here_raw_reg;
    logic               changed_reg;
    logic               res_state_reg;
    logic               res_evolved_reg;
    logic               res_oor_reg;
    logic               cell_state_reg;
    logic               evolved_reg;
    logic [GEN_W-1:0]   gen_out_reg;
    logic               oor_out_reg;

    logic [CNT_W-1:0]   used_rows;
    logic [CNT_W-1:0]   used_cols;
    row_word_t          col_mask;
    logic               accept;
    logic               in_range;
    logic               last_row;
    logic [CNT_W-1:0]   r_plus2;
    logic               slot_free;
    logic               step_changed;
    row_word_t          rd_data;
    row_word_t          rd_word;
    row_word_t          here_m;
    row_word_t          below_m;
    row_word_t          fresh;
    row_word_t          bit_sel;
    row_word_t          mod_word;

    logic               ram_we;
    logic [ROW_W-1:0]   ram_wr_addr;
    row_word_t          ram_wr_data;
    logic [ROW_W-1:0]   ram_rd_addr;

    las_ram #(
        .WIDTH (GRID_COLS),
        .DEPTH (GRID_ROWS)
    ) u_grid (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (rd_data)
    );

    las_row_unit u_rule (
        .rule_mode (rule_mode_reg),
        .col_mask  (col_mask),
        .above     (above_reg),
        .here      (here_m),
        .below     (below_m),
        .fresh     (fresh)
    );

    assign used_rows = (rows_cfg_reg > CNT_W'(GRID_ROWS)) ? CNT_W'(GRID_ROWS) : rows_cfg_reg;
    assign used_cols = (cols_cfg_reg > CNT_W'(GRID_COLS)) ? CNT_W'(GRID_COLS) : cols_cfg_reg;

    always_comb
    begin
        for (int c = 0; c < GRID_COLS; c++)
        begin
            col_mask[c] = CNT_W'(c) < used_cols;
        end
    end

    assign in_ready     = (state_reg == ST_IDLE);
    assign accept       = in_valid && in_ready;
    assign in_range     = (CNT_W'(row_reg) < used_rows) && (CNT_W'(col_reg) < used_cols);
    assign last_row     = (CNT_W'(r_reg) == used_rows - CNT_W'(1));
    assign r_plus2      = CNT_W'(r_reg) + CNT_W'(2);
    assign slot_free    = !out_valid_reg || out_ready;
    assign rd_word      = rd_valid_reg ? rd_data : '0;
    assign here_m       = here_raw_reg & col_mask;
    assign below_m      = last_row ? '0 : (rd_word & col_mask);
    assign step_changed = changed_reg || (fresh != here_m);
    assign bit_sel      = row_word_t'(1) << col_reg;

    always_comb
    begin
        case (func_reg)
            FUNC_WRITE:  mod_word = (rd_word & ~bit_sel) | (value_reg ? bit_sel : '0);
            FUNC_TOGGLE: mod_word = rd_word ^ bit_sel;
            default:     mod_word = rd_word;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (func == FUNC_WRITE || func == FUNC_TOGGLE || func == FUNC_READ)
                    begin
                        state_next = ST_ACC_RD;
                    end
                    else if (func == FUNC_STEP)
                    begin
                        state_next = ST_STEP_RD;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_ACC_RD:    state_next = in_range ? ST_ACC_MOD : ST_DONE;
            ST_ACC_MOD:   state_next = ST_DONE;
            ST_STEP_RD:   state_next = (used_rows == '0) ? ST_DONE : ST_STEP_LOAD;
            ST_STEP_LOAD: state_next = ST_STEP_ROW;
            ST_STEP_ROW:  state_next = last_row ? ST_DONE : ST_STEP_ROW;
            ST_DONE:      state_next = slot_free ? ST_IDLE : ST_DONE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // memory port control
    always_comb
    begin
        ram_we      = 1'b0;
        ram_wr_addr = r_reg;
        ram_wr_data = (here_raw_reg & ~col_mask) | fresh;
        ram_rd_addr = '0;
        case (state_reg)
            ST_ACC_RD:
            begin
                ram_rd_addr = row_reg;
            end
            ST_ACC_MOD:
            begin
                ram_we      = 1'b1;
                ram_wr_addr = row_reg;
                ram_wr_data = mod_word;
            end
            ST_STEP_LOAD:
            begin
                ram_rd_addr = ROW_W'(1);
            end
            ST_STEP_ROW:
            begin
                ram_we      = 1'b1;
                ram_rd_addr = r_plus2[ROW_W-1:0];
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rule_mode_reg <= 1'b0;
            rows_cfg_reg  <= CNT_W'(64);
            cols_cfg_reg  <= CNT_W'(64);
            gen_reg       <= '0;
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= row_valid_reg[ram_rd_addr];
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RULE_MODE: rule_mode_reg <= cfg_data[0];
                    CFG_ROWS:      rows_cfg_reg  <= cfg_data;
                    CFG_COLS:      cols_cfg_reg  <= cfg_data;
                    default:       rule_mode_reg <= rule_mode_reg;
                endcase
            end
            if (accept && func == FUNC_CLEAR)
            begin
                row_valid_reg <= '0;
                gen_reg       <= '0;
            end
            if (ram_we)
            begin
                row_valid_reg[ram_wr_addr] <= 1'b1;
            end
            if (state_reg == ST_STEP_ROW && last_row)
            begin
                gen_reg <= gen_reg + GEN_W'(step_changed);
            end
            if (state_reg == ST_DONE && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg        <= func;
            row_reg         <= cell_row;
            col_reg         <= cell_col;
            value_reg       <= cell_value;
            res_state_reg   <= 1'b0;
            res_evolved_reg <= 1'b0;
            res_oor_reg     <= 1'b0;
        end
        case (state_reg)
            ST_ACC_RD:
            begin
                res_oor_reg <= !in_range;
            end
            ST_ACC_MOD:
            begin
                res_state_reg <= mod_word[col_reg];
            end
            ST_STEP_RD:
            begin
                changed_reg <= 1'b0;
                r_reg       <= '0;
            end
            ST_STEP_LOAD:
            begin
                above_reg    <= '0;
                here_raw_reg <= rd_word;
            end
            ST_STEP_ROW:
            begin
                above_reg    <= here_m;
                here_raw_reg <= rd_word;
                r_reg        <= r_reg + ROW_W'(1);
                changed_reg  <= step_changed;
                if (last_row)
                begin
                    res_evolved_reg <= step_changed;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    cell_state_reg <= res_state_reg;
                    evolved_reg    <= res_evolved_reg;
                    gen_out_reg    <= gen_reg;
                    oor_out_reg    <= res_oor_reg;
                end
            end
            default:
            begin
                changed_reg <= changed_reg;
            end
        endcase
    end

    assign out_valid        = out_valid_reg;
    assign cell_state       = cell_state_reg;
    assign evolved          = evolved_reg;
    assign generation_count = gen_out_reg;
    assign out_of_range     = oor_out_reg;

endmodule
